/* hw/rtl/bkd_pkg.sv */
// bkd_pkg: shared constants and the usage-to-character map for the
// boot keyboard report event decoder
// no dependencies
package bkd_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [5:0] MIN_REPORT_LEN = 6'd8;
    localparam logic [7:0] SHIFT_MASK = 8'h22;

    localparam logic EV_DOWN = 1'b0;
    localparam logic EV_UP = 1'b1;

    // us layout; 0 means unmapped
    function automatic logic [6:0] usage_to_char(input logic [7:0] u, input logic sh);
        logic [7:0] t;
        t = 8'h00;
        if (u >= 8'h04 && u <= 8'h1d) begin
            t = (sh ? 8'h41 : 8'h61) + (u - 8'h04);
        end else if (!sh && u >= 8'h1e && u <= 8'h26) begin
            t = 8'h31 + (u - 8'h1e);
        end else begin
            unique case (u)
                8'h1e: t = sh ? 8'h21 : 8'h31;
                8'h1f: t = sh ? 8'h40 : 8'h32;
                8'h20: t = sh ? 8'h23 : 8'h33;
                8'h21: t = sh ? 8'h24 : 8'h34;
                8'h22: t = sh ? 8'h25 : 8'h35;
                8'h23: t = sh ? 8'h5e : 8'h36;
                8'h24: t = sh ? 8'h26 : 8'h37;
                8'h25: t = sh ? 8'h2a : 8'h38;
                8'h26: t = sh ? 8'h28 : 8'h39;
                8'h27: t = sh ? 8'h29 : 8'h30;
                8'h28: t = 8'h0a;
                8'h2c: t = 8'h20;
                8'h2d: t = sh ? 8'h5f : 8'h2d;
                8'h2e: t = sh ? 8'h2b : 8'h3d;
                8'h2f: t = sh ? 8'h7b : 8'h5b;
                8'h30: t = sh ? 8'h7d : 8'h5d;
                8'h33: t = sh ? 8'h3a : 8'h3b;
                8'h34: t = sh ? 8'h22 : 8'h27;
                8'h36: t = sh ? 8'h3c : 8'h2c;
                8'h37: t = sh ? 8'h3e : 8'h2e;
                8'h38: t = sh ? 8'h3f : 8'h2f;
                default: t = 8'h00;
            endcase
        end
        return t[6:0];
    endfunction

endpackage

/* hw/rtl/bkd_if.sv */
// bkd_in_if / bkd_out_if: valid/ready channels for reports and key events
// depends on nothing; widths follow the key slot count
interface bkd_in_if #(
    parameter int KEY_SLOTS = 6
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             modifier_byte;
    logic [KEY_SLOTS*8-1:0] key_slot;
    logic [5:0]             report_length;

    modport source (output valid, output modifier_byte, output key_slot,
                    output report_length, input ready);
    modport sink (input valid, input modifier_byte, input key_slot,
                  input report_length, output ready);
endinterface

interface bkd_out_if;
    logic       valid;
    logic       ready;
    logic       event_kind;
    logic [7:0] usage_code;
    logic       char_valid;
    logic [6:0] ascii_code;
    logic [7:0] modifier_bits;
    logic       last_event;

    modport source (output valid, output event_kind, output usage_code,
                    output char_valid, output ascii_code, output modifier_bits,
                    output last_event, input ready);
    modport sink (input valid, input event_kind, input usage_code,
                  input char_valid, input ascii_code, input modifier_bits,
                  input last_event, output ready);
endinterface

/* hw/rtl/bkd_queue.sv */
// bkd_queue: small word queue between the front and back ends
// depends on bkd_pkg for the depth
module bkd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_push_ready,
    input  logic         i_pop,
    output logic         o_pop_valid,
    output logic [W-1:0] o_rdata
);
    localparam int D = bkd_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [PW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_push_ready = (r_cnt != CW'(D));
    assign o_pop_valid  = (r_cnt != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_rdata      = r_mem[r_rd];
    assign n_wr = (r_wr == PW'(D - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(D - 1)) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= n_wr;
            if (do_pop) r_rd <= n_rd;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

/* hw/rtl/bkd_front.sv */
// bkd_front: takes reports, compares them with the stored key set and
// queues a word of down/up masks; depends on bkd_pkg and bkd_in_if
module bkd_front #(
    parameter int KEY_SLOTS = bkd_pkg::KEY_SLOTS_DEF,
    parameter int EW = 2 * KEY_SLOTS * 8 + 2 * KEY_SLOTS + 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    bkd_in_if.sink        i_report,
    output logic          o_push,
    output logic [EW-1:0] o_wdata,
    input  logic          i_push_ready
);
    localparam int KW = KEY_SLOTS * 8;

    logic                 r_enable;
    logic [KW-1:0]        r_prev;
    logic [KEY_SLOTS-1:0] down_mask, up_mask;
    logic                 accept, process;

    assign i_report.ready = i_push_ready;
    assign accept  = i_report.valid && i_push_ready;
    assign process = r_enable && (i_report.report_length >= bkd_pkg::MIN_REPORT_LEN);

    // every slot against every slot of the other set
    always_comb begin
        logic hit_prev, hit_new;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            hit_prev = 1'b0;
            hit_new  = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (i_report.key_slot[i*8 +: 8] == r_prev[j*8 +: 8]) hit_prev = 1'b1;
                if (r_prev[i*8 +: 8] == i_report.key_slot[j*8 +: 8]) hit_new = 1'b1;
            end
            down_mask[i] = (i_report.key_slot[i*8 +: 8] != 8'h00) && !hit_prev;
            up_mask[i]   = (r_prev[i*8 +: 8] != 8'h00) && !hit_new;
        end
    end

    assign o_push  = accept && process && ((down_mask | up_mask) != '0);
    assign o_wdata = {i_report.modifier_byte, up_mask, down_mask, r_prev,
                      i_report.key_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (i_cfg_we) r_enable <= i_cfg_wdata;
            if (accept && process) r_prev <= i_report.key_slot;
        end
    end
endmodule

/* hw/rtl/bkd_back.sv */
// bkd_back: walks the masks of one queued word, one event a cycle unless
// ready holds it, into the output register; needs bkd_pkg and bkd_out_if
module bkd_back #(
    parameter int KEY_SLOTS = bkd_pkg::KEY_SLOTS_DEF,
    parameter int EW = 2 * KEY_SLOTS * 8 + 2 * KEY_SLOTS + 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  logic [EW-1:0] i_rdata,
    output logic          o_pop,
    bkd_out_if.source     o_event
);
    localparam int KW = KEY_SLOTS * 8;
    localparam int MW = 2 * KEY_SLOTS;

    logic            r_busy;
    logic [MW-1:0]   r_mask;
    logic [2*KW-1:0] r_codes;   // new slots low, stored slots high
    logic [7:0]      r_mods;
    logic [MW-1:0]   pick, rest;
    logic [7:0]      sel_code;
    logic            sel_up, advance, last;

    logic            r_ov, r_kind, r_cv, r_last;
    logic [7:0]      r_code, r_mbits;
    logic [6:0]      r_ascii;
    logic [6:0]      ch;

    assign pick = r_mask & (~r_mask + MW'(1));
    assign rest = r_mask & ~pick;
    assign last = (rest == '0);
    assign advance = r_busy && (!r_ov || o_event.ready);
    assign o_pop = i_pop_valid && (!r_busy || (advance && last));

    always_comb begin
        sel_code = 8'h00;
        sel_up   = 1'b0;
        for (int i = 0; i < MW; i++) begin
            if (pick[i]) sel_code = sel_code | r_codes[i*8 +: 8];
        end
        if (pick[MW-1:KEY_SLOTS] != '0) sel_up = 1'b1;
    end

    assign ch = (sel_up == bkd_pkg::EV_DOWN)
              ? bkd_pkg::usage_to_char(sel_code, (r_mods & bkd_pkg::SHIFT_MASK) != 8'h00)
              : 7'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance && last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_ov <= 1'b1;
            end else if (o_event.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_codes <= i_rdata[2*KW-1:0];
            r_mask  <= i_rdata[2*KW +: MW];
            r_mods  <= i_rdata[EW-1 -: 8];
        end else if (advance) begin
            r_mask <= rest;
        end
        if (advance) begin
            r_kind  <= sel_up;
            r_code  <= sel_code;
            r_cv    <= (ch != 7'h00);
            r_ascii <= ch;
            r_mbits <= r_mods;
            r_last  <= last;
        end
    end

    assign o_event.valid         = r_ov;
    assign o_event.event_kind    = r_kind;
    assign o_event.usage_code    = r_code;
    assign o_event.char_valid    = r_cv;
    assign o_event.ascii_code    = r_ascii;
    assign o_event.modifier_bits = r_mbits;
    assign o_event.last_event    = r_last;
endmodule

/* hw/rtl/boot_keyboard_report_event_decoder.sv */
// boot_keyboard_report_event_decoder: top level, front end, queue, back end
// depends on bkd_pkg, bkd_if, bkd_front, bkd_queue, bkd_back

// A report is taken whenever the two-word queue between the front and back
// ends has room, so reports may arrive back to back. The front end compares
// the new key slots with the stored set, stores the new set and queues a
// word only if some key went down or up; disabled, short or unchanged
// reports leave with no events. The back end hands out one event per cycle
// through its output register while o_event.ready does not stall it; a
// report carries at most twice the slot count of events, twelve with six
// slots, and that event walk sets the sustained rate.
// Key down events come first in slot order, then key up events, and the last
// event of a report has last_event set. The enable register is written with
// i_cfg_we and is cleared by reset, as is the stored key set.
module boot_keyboard_report_event_decoder #(
    parameter int KEY_SLOTS = bkd_pkg::KEY_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    bkd_in_if.sink    i_report,
    bkd_out_if.source o_event
);
    localparam int EW = 2 * KEY_SLOTS * 8 + 2 * KEY_SLOTS + 8;

    logic          q_push, q_push_ready, q_pop, q_pop_valid;
    logic [EW-1:0] q_wdata, q_rdata;

    bkd_front #(.KEY_SLOTS(KEY_SLOTS), .EW(EW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_report     (i_report),
        .o_push       (q_push),
        .o_wdata      (q_wdata),
        .i_push_ready (q_push_ready)
    );

    bkd_queue #(.W(EW)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_wdata      (q_wdata),
        .o_push_ready (q_push_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_pop_valid),
        .o_rdata      (q_rdata)
    );

    bkd_back #(.KEY_SLOTS(KEY_SLOTS), .EW(EW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .i_rdata     (q_rdata),
        .o_pop       (q_pop),
        .o_event     (o_event)
    );

    // a queued word always carries at least one event
    a_push_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_wdata[2*KEY_SLOTS*8 +: 2*KEY_SLOTS] != '0))
        else $error("queued word with empty masks");

    // the front end only pushes when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> q_push_ready)
        else $error("push into a full queue");

    // key up events never carry a character
    a_up_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.event_kind == bkd_pkg::EV_UP)
            |-> (!o_event.char_valid && o_event.ascii_code == 7'h00))
        else $error("key up event with a character");

    // char_valid tracks a nonzero character
    a_char_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid |-> (o_event.char_valid == (o_event.ascii_code != 7'h00)))
        else $error("char_valid disagrees with ascii_code");
endmodule
